[design/rvb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvb_pkg
// shared types and constants for the stereo comb/allpass reverb
// ----------------------------------------------------------------------------
package rvb_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIX          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_ONE_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMB_TWO_LEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSER_LEN = 3'd4;

  // register reset values
  localparam logic [15:0] MIX_RESET          = 16'd16384;
  localparam logic [14:0] DECAY_RESET        = 15'd19661;
  localparam logic [11:0] COMB_ONE_LEN_RESET = 12'd1425;
  localparam logic [11:0] COMB_TWO_LEN_RESET = 12'd1780;
  localparam logic [8:0]  DIFFUSER_LEN_RESET = 9'd240;

  // fully wet mix level
  localparam logic [15:0] MIX_FULL = 16'd32768;

  // rounding offset for q15 products
  localparam int RND_HALF = 16384;

  // output sample limits
  localparam logic [SAMPLE_W-1:0] Y_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] Y_MIN = 16'h8000;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = 2;

  // lane control: one bit per pipeline step, plus the write enables and the clear flag
  typedef struct packed {
    logic st0;      // beat accepted, line reads launched
    logic st1;      // comb products, diffuser write-back
    logic st2;      // comb write-back, mix products
    logic comb_we;
    logic diff_we;
    logic clear;    // clearing pass, write zeros
  } rvb_ctl_t;

  typedef struct packed {
    logic                last;
    logic [SAMPLE_W-1:0] right;
    logic [SAMPLE_W-1:0] left;
  } rvb_res_t;

endpackage

[design/rvb_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvb_lane
// one audio channel: two feedback comb lines, a diffuser line and the
// dry/wet mix
// ----------------------------------------------------------------------------
module rvb_lane
  import rvb_pkg::*;
#(
  parameter int COMB_DEPTH     = 2048,
  parameter int DIFFUSER_DEPTH = 256,
  parameter int STORE_WIDTH    = 24
) (
  input  logic                          clk,
  input  rvb_ctl_t                      ctl,
  input  logic signed [SAMPLE_W-1:0]    sample_in,
  input  logic [14:0]                   decay_gain,
  input  logic [15:0]                   mix,
  input  logic [15:0]                   dry,
  input  logic [$clog2(COMB_DEPTH)-1:0] comb_one_rd_addr,
  input  logic [$clog2(COMB_DEPTH)-1:0] comb_two_rd_addr,
  input  logic [$clog2(DIFFUSER_DEPTH)-1:0] diff_rd_addr,
  input  logic [$clog2(COMB_DEPTH)-1:0] comb_one_wr_addr,
  input  logic [$clog2(COMB_DEPTH)-1:0] comb_two_wr_addr,
  input  logic [$clog2(DIFFUSER_DEPTH)-1:0] diff_wr_addr,
  output logic [SAMPLE_W-1:0]           sample_out
);

  localparam int SW  = STORE_WIDTH;
  localparam int PW  = SW + 16;
  localparam int DPW = SAMPLE_W + 17;
  localparam int WPW = SW + 18;
  localparam int OW  = SW + 19;
  localparam int YW  = SW + 4;

  logic signed [SW-1:0] comb_one_mem [COMB_DEPTH];
  logic signed [SW-1:0] comb_two_mem [COMB_DEPTH];
  logic signed [SW-1:0] diff_mem [DIFFUSER_DEPTH];

  logic signed [SAMPLE_W-1:0] x0;
  logic signed [SAMPLE_W-1:0] x1;
  logic signed [SW-1:0]       d1;
  logic signed [SW-1:0]       d2;
  logic signed [SW-1:0]       a;
  logic signed [SW:0]         c_sum;
  logic signed [SW-1:0]       c;
  logic signed [SW:0]         half_sum;
  logic signed [SW-1:0]       half;
  logic signed [SW:0]         diff_sum;
  logic signed [SW:0]         w1;
  logic signed [PW-1:0]       prod1;
  logic signed [PW-1:0]       prod2;
  logic signed [PW-1:0]       rsum1;
  logic signed [PW-1:0]       rsum2;
  logic signed [SW:0]         r1;
  logic signed [SW:0]         r2;
  logic signed [SW+1:0]       cw_sum1;
  logic signed [SW+1:0]       cw_sum2;
  logic signed [SW-1:0]       comb_one_wd;
  logic signed [SW-1:0]       comb_two_wd;
  logic signed [SW-1:0]       diff_wd;
  logic signed [DPW-1:0]      pd;
  logic signed [WPW-1:0]      pw;
  logic signed [OW-1:0]       ysum;
  logic signed [YW-1:0]       yfull;

  function automatic logic signed [SW-1:0] sat_wide(input logic signed [SW+1:0] v);
    if ((&v[SW+1:SW-1]) || !(|v[SW+1:SW-1])) begin
      return v[SW-1:0];
    end else if (v[SW+1]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [SW-1:0] sat_narrow(input logic signed [SW:0] v);
    if (v[SW] == v[SW-1]) begin
      return v[SW-1:0];
    end else if (v[SW]) begin
      return {1'b1, {(SW-1){1'b0}}};
    end else begin
      return {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  // line reads, registered
  always_ff @(posedge clk) begin
    if (ctl.st0) begin
      d1 <= comb_one_mem[comb_one_rd_addr];
      d2 <= comb_two_mem[comb_two_rd_addr];
      a  <= diff_mem[diff_rd_addr];
      x0 <= sample_in;
    end
  end

  // line writes
  always_ff @(posedge clk) begin
    if (ctl.comb_we) begin
      comb_one_mem[comb_one_wr_addr] <= comb_one_wd;
      comb_two_mem[comb_two_wr_addr] <= comb_two_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.diff_we) begin
      diff_mem[diff_wr_addr] <= diff_wd;
    end
  end

  // comb average and diffuser
  always_comb begin
    c_sum    = (SW+1)'(d1) + (SW+1)'(d2) + (SW+1)'(1);
    c        = c_sum[SW:1];
    half_sum = (SW+1)'(a) + (SW+1)'(1);
    half     = half_sum[SW:1];
    diff_sum = (SW+1)'(c) + (SW+1)'(half);
    diff_wd  = ctl.clear ? '0 : sat_narrow(diff_sum);
  end

  always_ff @(posedge clk) begin
    if (ctl.st1) begin
      prod1 <= PW'(d1) * PW'($signed({1'b0, decay_gain}));
      prod2 <= PW'(d2) * PW'($signed({1'b0, decay_gain}));
      w1    <= (SW+1)'(a) - (SW+1)'(c);
      x1    <= x0;
    end
  end

  // comb write-back: input plus rounded feedback
  always_comb begin
    rsum1       = prod1 + PW'(RND_HALF);
    rsum2       = prod2 + PW'(RND_HALF);
    r1          = rsum1[PW-1:15];
    r2          = rsum2[PW-1:15];
    cw_sum1     = (SW+2)'(x1) + (SW+2)'(r1);
    cw_sum2     = (SW+2)'(x1) + (SW+2)'(r2);
    comb_one_wd = ctl.clear ? '0 : sat_wide(cw_sum1);
    comb_two_wd = ctl.clear ? '0 : sat_wide(cw_sum2);
  end

  always_ff @(posedge clk) begin
    if (ctl.st2) begin
      pd <= DPW'(x1) * DPW'($signed({1'b0, dry}));
      pw <= WPW'(w1) * WPW'($signed({1'b0, mix}));
    end
  end

  // dry/wet sum, round, clamp to 16 bits
  always_comb begin
    ysum  = OW'(pd) + OW'(pw) + OW'(RND_HALF);
    yfull = ysum[OW-1:15];
    if ((&yfull[YW-1:SAMPLE_W-1]) || !(|yfull[YW-1:SAMPLE_W-1])) begin
      sample_out = yfull[SAMPLE_W-1:0];
    end else if (yfull[YW-1]) begin
      sample_out = Y_MIN;
    end else begin
      sample_out = Y_MAX;
    end
  end

endmodule

[design/rvb_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvb_merge
// joins both lane results into one output beat and queues it
// ----------------------------------------------------------------------------
module rvb_merge
  import rvb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic                push,
  input  logic [SAMPLE_W-1:0] left_y,
  input  logic [SAMPLE_W-1:0] right_y,
  input  logic                last,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2*SAMPLE_W-1:0] out_data,
  output logic                out_last
);

  rvb_res_t          q [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr;
  logic [RES_AW-1:0] rd_ptr;
  logic [RES_AW:0]   fill;
  logic [RES_AW:0]   fill_next;
  logic [RES_AW:0]   credit;
  logic [RES_AW:0]   credit_next;
  logic              pop;
  rvb_res_t          head;

  assign pop       = out_valid && out_ready;
  assign head      = q[rd_ptr];
  assign out_valid = (fill != '0);
  assign out_data  = {head.right, head.left};
  assign out_last  = head.last;
  // credits cover results still in the lanes as well as queued ones
  assign room      = (credit < (RES_AW+1)'(RES_DEPTH));

  always_comb begin
    fill_next   = fill + (RES_AW+1)'(push) - (RES_AW+1)'(pop);
    credit_next = credit + (RES_AW+1)'(take) - (RES_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{last: last, right: right_y, left: left_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      credit <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + RES_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + RES_AW'(1);
      end
      fill   <= fill_next;
      credit <= credit_next;
    end
  end

endmodule

[design/stereo_comb_allpass_reverb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb
// stereo reverb: per channel two feedback comb lines, an averaging stage, a
// diffuser line and a dry/wet mix, left and right in two parallel lanes
// ----------------------------------------------------------------------------
// path: line-read, comb-product and mix-product registers, then the result queue
// pacing: the next stereo pair waits for the comb write-back of the previous one
//   (read-modify-write of the comb lines) and for room in the result queue
// reset: synchronous; registers return to their defaults, then a clearing pass
//   over max(COMB_DEPTH, DIFFUSER_DEPTH) addresses (2048 by default) zeroes the
//   lines with s_axis_tready low; config writes are taken throughout
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb
  import rvb_pkg::*;
#(
  parameter int COMB_DEPTH     = 2048,
  parameter int DIFFUSER_DEPTH = 256,
  parameter int STORE_WIDTH    = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  // input beat
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [15:0] left_in, [31:16] right_in
  input  logic                  s_axis_tlast,   // frame_last
  // result beat
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,   // [15:0] left_out, [31:16] right_out
  output logic                  m_axis_tlast,   // frame_last_out
  // config writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW        = $clog2(COMB_DEPTH);
  localparam int DW        = $clog2(DIFFUSER_DEPTH);
  localparam int CLR_DEPTH = (COMB_DEPTH > DIFFUSER_DEPTH) ? COMB_DEPTH : DIFFUSER_DEPTH;
  localparam int CLW       = $clog2(CLR_DEPTH);

  // config registers
  logic [15:0] mix_level;
  logic [14:0] decay_gain;
  logic [11:0] comb_one_length;
  logic [11:0] comb_two_length;
  logic [8:0]  diffuser_length;

  // shared line pointers and the copies held for write-back
  logic [CW-1:0] p1;
  logic [CW-1:0] p2;
  logic [DW-1:0] pa;
  logic [CW-1:0] p1_next;
  logic [CW-1:0] p2_next;
  logic [DW-1:0] pa_next;
  logic [CW-1:0] p1_wb;
  logic [CW-1:0] p2_wb;
  logic [DW-1:0] pa_wb;

  logic [CW:0] eff1;
  logic [CW:0] eff2;
  logic [DW:0] effa;
  logic [CW:0] p1_inc;
  logic [CW:0] p2_inc;
  logic [DW:0] pa_inc;

  // pipeline step valids
  logic v1;
  logic v2;
  logic v3;
  logic last_q;

  // clearing pass
  logic           clearing;
  logic [CLW-1:0] clr_cnt;
  logic           comb_clr_ok;
  logic           diff_clr_ok;

  logic        accept;
  logic        room;
  logic [15:0] mix_eff;
  logic [15:0] dry;

  rvb_ctl_t ctl;

  logic [CW-1:0] comb_one_wr_addr;
  logic [CW-1:0] comb_two_wr_addr;
  logic [DW-1:0] diff_wr_addr;

  logic [SAMPLE_W-1:0] left_y;
  logic [SAMPLE_W-1:0] right_y;

  // next beat may enter once the previous comb write-back is done, the clearing pass is over and the queue has room
  assign s_axis_tready = !clearing && !v1 && !v2 && room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  // mix above full acts as full
  assign mix_eff = (mix_level > MIX_FULL) ? MIX_FULL : mix_level;
  assign dry     = 16'(17'(MIX_FULL) - 17'(mix_eff));

  // effective lengths: zero acts as one, too long acts as the depth
  always_comb begin
    if (comb_one_length == '0) begin
      eff1 = (CW+1)'(1);
    end else if (32'(comb_one_length) > 32'(COMB_DEPTH)) begin
      eff1 = (CW+1)'(COMB_DEPTH);
    end else begin
      eff1 = (CW+1)'(comb_one_length);
    end

    if (comb_two_length == '0) begin
      eff2 = (CW+1)'(1);
    end else if (32'(comb_two_length) > 32'(COMB_DEPTH)) begin
      eff2 = (CW+1)'(COMB_DEPTH);
    end else begin
      eff2 = (CW+1)'(comb_two_length);
    end

    if (diffuser_length == '0) begin
      effa = (DW+1)'(1);
    end else if (32'(diffuser_length) > 32'(DIFFUSER_DEPTH)) begin
      effa = (DW+1)'(DIFFUSER_DEPTH);
    end else begin
      effa = (DW+1)'(diffuser_length);
    end

    // pointer wraps to zero once it reaches the effective length
    p1_inc  = (CW+1)'(p1) + (CW+1)'(1);
    p2_inc  = (CW+1)'(p2) + (CW+1)'(1);
    pa_inc  = (DW+1)'(pa) + (DW+1)'(1);
    p1_next = (p1_inc >= eff1) ? '0 : p1_inc[CW-1:0];
    p2_next = (p2_inc >= eff2) ? '0 : p2_inc[CW-1:0];
    pa_next = (pa_inc >= effa) ? '0 : pa_inc[DW-1:0];
  end

  // config register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_level       <= MIX_RESET;
      decay_gain      <= DECAY_RESET;
      comb_one_length <= COMB_ONE_LEN_RESET;
      comb_two_length <= COMB_TWO_LEN_RESET;
      diffuser_length <= DIFFUSER_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIX:          mix_level       <= cfg_data;
        REG_DECAY:        decay_gain      <= cfg_data[14:0];
        REG_COMB_ONE_LEN: comb_one_length <= cfg_data[11:0];
        REG_COMB_TWO_LEN: comb_two_length <= cfg_data[11:0];
        REG_DIFFUSER_LEN: diffuser_length <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // pointers advance on every accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '0;
      p2 <= '0;
      pa <= '0;
    end else if (accept) begin
      p1 <= p1_next;
      p2 <= p2_next;
      pa <= pa_next;
    end
  end

  // addresses and marker held until write-back and push
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_wb  <= p1;
      p2_wb  <= p2;
      pa_wb  <= pa;
      last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == CLW'(CLR_DEPTH - 1)) begin
        clearing <= 1'b0;
        clr_cnt  <= '0;
      end else begin
        clr_cnt <= clr_cnt + CLW'(1);
      end
    end
  end

  assign comb_clr_ok = (32'(clr_cnt) < 32'(COMB_DEPTH));
  assign diff_clr_ok = (32'(clr_cnt) < 32'(DIFFUSER_DEPTH));

  assign comb_one_wr_addr = clearing ? clr_cnt[CW-1:0] : p1_wb;
  assign comb_two_wr_addr = clearing ? clr_cnt[CW-1:0] : p2_wb;
  assign diff_wr_addr     = clearing ? clr_cnt[DW-1:0] : pa_wb;

  always_comb begin
    ctl.st0     = accept;
    ctl.st1     = v1;
    ctl.st2     = v2;
    ctl.comb_we = v2 || (clearing && comb_clr_ok);
    ctl.diff_we = v1 || (clearing && diff_clr_ok);
    ctl.clear   = clearing;
  end

  // left lane
  rvb_lane #(
    .COMB_DEPTH     (COMB_DEPTH),
    .DIFFUSER_DEPTH (DIFFUSER_DEPTH),
    .STORE_WIDTH    (STORE_WIDTH)
  ) u_lane_left (
    .clk              (clk),
    .ctl              (ctl),
    .sample_in        (s_axis_tdata[15:0]),
    .decay_gain       (decay_gain),
    .mix              (mix_eff),
    .dry              (dry),
    .comb_one_rd_addr (p1),
    .comb_two_rd_addr (p2),
    .diff_rd_addr     (pa),
    .comb_one_wr_addr (comb_one_wr_addr),
    .comb_two_wr_addr (comb_two_wr_addr),
    .diff_wr_addr     (diff_wr_addr),
    .sample_out       (left_y)
  );

  // right lane, same pointers
  rvb_lane #(
    .COMB_DEPTH     (COMB_DEPTH),
    .DIFFUSER_DEPTH (DIFFUSER_DEPTH),
    .STORE_WIDTH    (STORE_WIDTH)
  ) u_lane_right (
    .clk              (clk),
    .ctl              (ctl),
    .sample_in        (s_axis_tdata[31:16]),
    .decay_gain       (decay_gain),
    .mix              (mix_eff),
    .dry              (dry),
    .comb_one_rd_addr (p1),
    .comb_two_rd_addr (p2),
    .diff_rd_addr     (pa),
    .comb_one_wr_addr (comb_one_wr_addr),
    .comb_two_wr_addr (comb_two_wr_addr),
    .diff_wr_addr     (diff_wr_addr),
    .sample_out       (right_y)
  );

  // both lanes land in one output beat; queue lets the input run on
  // while the output side stalls
  rvb_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .take      (accept),
    .push      (v3),
    .left_y    (left_y),
    .right_y   (right_y),
    .last      (last_q),
    .room      (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
